// ----- design/trbf_pkg.sv -----
// Shared types and constants of the telemetry ring burst framer.
// No dependencies; used by every module of the block.
package trbf_pkg;

  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned MAX_BURST  = 10;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SNAP_W  = CHANNELS * WORD_W;
  localparam int unsigned PTR_W   = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_BURST + 1);
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned OUTC_W  = 2;

  localparam logic [LIMIT_W-1:0] BURST_LIMIT_RST = LIMIT_W'(10);
  localparam logic [OUTC_W-1:0]  OUTCOME_OK      = OUTC_W'(0);

  localparam int unsigned IN_FIELDS_W  = SNAP_W + 1 + OUTC_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = SNAP_W + FILL_W + 2 * WORD_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned IDLE_BIT = SNAP_W;
  localparam int unsigned OUTC_LSB = SNAP_W + 1;

  typedef enum logic {
    OP_CAPTURE = 1'b0,
    OP_SEND    = 1'b1
  } opcode_e;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- design/trbf_ring_mem.sv -----
// Snapshot ring storage: one write port, one registered read port.
// Depends on trbf_pkg for widths and the request struct.
module trbf_ring_mem (
  input  logic                       clk_i,
  input  trbf_pkg::mem_req_t         req_i,
  input  logic [trbf_pkg::SNAP_W-1:0] wdata_i,
  output logic [trbf_pkg::SNAP_W-1:0] rdata_o
);

  logic [trbf_pkg::SNAP_W-1:0] ram_q [trbf_pkg::RING_DEPTH];
  logic [trbf_pkg::SNAP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      ram_q[req_i.waddr] <= wdata_i;
    end
    if (req_i.re) begin
      rdata_q <= ram_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/trbf_ctrl.sv -----
// Ring pointers, fill level, counters and burst sequencer.
// Depends on trbf_pkg; drives the request port of trbf_ring_mem.
module trbf_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  trbf_pkg::opcode_e              opcode_i,
  input  logic                           link_idle_i,
  input  logic [trbf_pkg::OUTC_W-1:0]    outcome_i,
  input  logic [trbf_pkg::LIMIT_W-1:0]   limit_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic                           m_last_o,
  output logic [trbf_pkg::FILL_W-1:0]    backlog_o,
  output logic [trbf_pkg::WORD_W-1:0]    dropped_o,
  output logic [trbf_pkg::WORD_W-1:0]    sent_o,
  output trbf_pkg::mem_req_t             mem_req_o
);

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_e;

  state_e                         state_q, state_d;
  logic [trbf_pkg::PTR_W-1:0]     wp_q, wp_d;
  logic [trbf_pkg::PTR_W-1:0]     rp_q, rp_d;
  logic [trbf_pkg::FILL_W-1:0]    fill_q, fill_d;
  logic [trbf_pkg::WORD_W-1:0]    drop_q, drop_d;
  logic [trbf_pkg::WORD_W-1:0]    sent_q, sent_d;
  logic [trbf_pkg::CNT_W-1:0]     left_q, left_d;

  logic                           in_xact;
  logic                           out_xact;
  logic                           tick_go;
  logic [trbf_pkg::CNT_W-1:0]     limit_eff;
  logic [trbf_pkg::CNT_W-1:0]     count;
  logic [trbf_pkg::PTR_W-1:0]     wp_next;
  logic [trbf_pkg::PTR_W-1:0]     rp_next;

  assign s_ready_o = (state_q == S_IDLE);
  assign in_xact   = s_valid_i && s_ready_o;
  assign out_xact  = m_valid_o && m_ready_i;

  assign tick_go = in_xact && (opcode_i == trbf_pkg::OP_SEND) && link_idle_i
                   && (outcome_i == trbf_pkg::OUTCOME_OK) && (fill_q != '0);

  always_comb begin
    if (limit_i == '0) begin
      limit_eff = trbf_pkg::CNT_W'(1);
    end else if (trbf_pkg::CNT_W'(limit_i) > trbf_pkg::CNT_W'(trbf_pkg::MAX_BURST)) begin
      limit_eff = trbf_pkg::CNT_W'(trbf_pkg::MAX_BURST);
    end else begin
      limit_eff = trbf_pkg::CNT_W'(limit_i);
    end
  end

  assign count = (fill_q < trbf_pkg::FILL_W'(limit_eff)) ? trbf_pkg::CNT_W'(fill_q) : limit_eff;

  assign wp_next = (wp_q == trbf_pkg::PTR_W'(trbf_pkg::RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == trbf_pkg::PTR_W'(trbf_pkg::RING_DEPTH - 1)) ? '0 : rp_q + 1'b1;

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    fill_d  = fill_q;
    drop_d  = drop_q;
    sent_d  = sent_q;
    left_d  = left_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wp_q;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = rp_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xact && (opcode_i == trbf_pkg::OP_CAPTURE)) begin
          mem_req_o.we = 1'b1;
          wp_d = wp_next;
          if (fill_q < trbf_pkg::FILL_W'(trbf_pkg::RING_DEPTH)) begin
            fill_d = fill_q + 1'b1;
          end else begin
            rp_d   = rp_next;
            drop_d = drop_q + 1'b1;
          end
        end else if (tick_go) begin
          mem_req_o.re = 1'b1;
          rp_d    = rp_next;
          fill_d  = fill_q - trbf_pkg::FILL_W'(count);
          sent_d  = sent_q + trbf_pkg::WORD_W'(count);
          left_d  = count;
          state_d = S_BURST;
        end
      end
      S_BURST: begin
        if (out_xact) begin
          if (left_q == trbf_pkg::CNT_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            mem_req_o.re = 1'b1;
            rp_d   = rp_next;
            left_d = left_q - 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      fill_q  <= '0;
      drop_q  <= '0;
      sent_q  <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      sent_q  <= sent_d;
      left_q  <= left_d;
    end
  end

  assign m_valid_o = (state_q == S_BURST);
  assign m_last_o  = (left_q == trbf_pkg::CNT_W'(1));
  assign backlog_o = fill_q;
  assign dropped_o = drop_q;
  assign sent_o    = sent_q;

endmodule

// ----- design/telemetry_ring_burst_framer_top.sv -----
// Top level of the telemetry ring burst framer: stream ports, limit register.
// Depends on trbf_pkg, trbf_ctrl and trbf_ring_mem.
//
// A capture transaction stores a snapshot in a 32-entry ring; captures may
// arrive every cycle while no burst is in flight. A send tick that is taken
// starts a burst of up to burst_limit frames (0 counts as 1, capped at 10)
// read oldest first from the ring memory: the first frame appears in the
// cycle after the tick, as the memory read is registered, and each further
// frame in the cycle after the previous one is taken. No input is taken
// while a burst is in flight. A refused tick or a capture yields no frame.
// Counters and backlog in each frame already include the whole burst.
module telemetry_ring_burst_framer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [trbf_pkg::LIMIT_W-1:0]       cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // sample0..sample7, link_idle, write_outcome, zero pad
  input  logic [trbf_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // opcode
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // word0..word7, backlog, dropped_total, sent_total, zero pad
  output logic [trbf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  logic [trbf_pkg::LIMIT_W-1:0]   limit_q;
  trbf_pkg::mem_req_t             mem_req;
  logic [trbf_pkg::SNAP_W-1:0]    rdata;
  logic [trbf_pkg::FILL_W-1:0]    backlog;
  logic [trbf_pkg::WORD_W-1:0]    dropped;
  logic [trbf_pkg::WORD_W-1:0]    sent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= trbf_pkg::BURST_LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  trbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .opcode_i    (trbf_pkg::opcode_e'(s_axis_tuser_i)),
    .link_idle_i (s_axis_tdata_i[trbf_pkg::IDLE_BIT]),
    .outcome_i   (s_axis_tdata_i[trbf_pkg::OUTC_LSB +: trbf_pkg::OUTC_W]),
    .limit_i     (limit_q),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_last_o    (m_axis_tlast_o),
    .backlog_o   (backlog),
    .dropped_o   (dropped),
    .sent_o      (sent),
    .mem_req_o   (mem_req)
  );

  trbf_ring_mem u_ring (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .wdata_i (s_axis_tdata_i[trbf_pkg::SNAP_W-1:0]),
    .rdata_o (rdata)
  );

  assign m_axis_tdata_o = trbf_pkg::OUT_TDATA_W'({sent, dropped, backlog, rdata});

  a_no_input_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken during burst");

  a_backlog_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    backlog <= trbf_pkg::FILL_W'(trbf_pkg::RING_DEPTH))
    else $error("backlog above ring depth");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o)
      |=> (m_axis_tvalid_o && $stable(sent) && $stable(backlog)))
    else $error("burst ended early or status moved");

  a_capture_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i) |=> !m_axis_tvalid_o)
    else $error("capture produced a frame");

endmodule
